// ===== hdl/fret_pkg.sv =====
// Shared constants for the relaxed FIFO rank error tracker.
`default_nettype none
package fret_pkg;

    localparam int STATUS_W = 2;
    localparam int RANK_W   = 10;
    localparam int SUM_W    = 20;
    localparam int GETS_W   = 11;
    localparam int KEY_W    = 32;

    localparam logic [STATUS_W-1:0] ST_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [RANK_W-1:0] RANK_MAX = 10'd1023;
    localparam logic [SUM_W-1:0]  SUM_MAX  = 20'd1048575;
    localparam logic [GETS_W-1:0] GETS_MAX = 11'd2047;

endpackage
`default_nettype wire

// ===== hdl/fifo_rank_error_tracker.sv =====
// Relaxed FIFO rank error tracker: key store, sequential scan and running statistics.
//
// A put appends its key to the next free slot of an ordered store of ENTRIES keys
// (slots are never reused) and answers "stored", or "full" once every slot has been
// used. A get scans the slots written so far from the oldest, one slot per cycle
// through the single read port of the key memory and one shared key comparator,
// counts the live keys ahead of the first live match, removes the match and updates
// the running rank-error sum, maximum and successful get count; a miss answers "not
// found" and changes nothing. Every word in gives one result word out, and the
// statistic outputs always show the totals including that word. A put goes
// straight to its result without a scan; a get scans at most fill_count slots
// (at most ENTRIES), one read per cycle of the key memory. The input side is not
// ready while a word is in work; a finished result waits in the output register
// while the next word is taken. There is no clearing pass after reset: the fill
// count bounds every scan, so only written slots are ever used.
`default_nettype none
module fifo_rank_error_tracker
    import fret_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_op,
    input  wire logic [KEY_W-1:0]    i_key,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [RANK_W-1:0]        o_rank_err,
    output logic [SUM_W-1:0]         o_error_sum,
    output logic [RANK_W-1:0]        o_error_max,
    output logic [GETS_W-1:0]        o_gets_done
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] FILL_FULL = CW'(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;

    // storage
    logic [KEY_W-1:0] key_mem  [ENTRIES];
    logic             live_mem [ENTRIES];
    logic [KEY_W-1:0] r_key_rd;
    logic             r_live_rd;

    // sequencer
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_rd_addr;
    logic [AW-1:0]       r_rd_idx;
    logic                r_rd_pend;
    logic [CW-1:0]       r_ahead;
    logic [KEY_W-1:0]    r_key;
    logic [STATUS_W-1:0] r_pend_status;
    logic [RANK_W-1:0]   r_pend_rank;

    // result and statistics
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [RANK_W-1:0]   r_rank;
    logic [SUM_W-1:0]    r_sum;
    logic [RANK_W-1:0]   r_max;
    logic [GETS_W-1:0]   r_gets;

    logic              accept;
    logic              put_ok;
    logic              hit;
    logic              load;
    logic              live_we;
    logic [AW-1:0]     live_wa;
    logic              live_wd;
    logic [31:0]       ahead_ext;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  n_sum;

    assign accept    = i_in_valid && o_in_ready;
    assign put_ok    = accept && (i_op == OP_PUT) && (r_fill < FILL_FULL);
    assign hit       = (r_state == S_SCAN) && r_rd_pend && r_live_rd && (r_key_rd == r_key);
    assign load      = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign ahead_ext = 32'(r_ahead);
    assign sum_add   = {1'b0, r_sum} + (SUM_W+1)'(r_pend_rank);
    assign n_sum     = (sum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];

    always_comb begin
        live_we = 1'b0;
        live_wa = r_fill[AW-1:0];
        live_wd = 1'b1;
        if (put_ok) begin
            live_we = 1'b1;
        end else if (hit) begin
            live_we = 1'b1;
            live_wa = r_rd_idx;
            live_wd = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_ok) begin
            key_mem[r_fill[AW-1:0]] <= i_key;
        end
        r_key_rd <= key_mem[r_rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (live_we) begin
            live_mem[live_wa] <= live_wd;
        end
        r_live_rd <= live_mem[r_rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_max       <= '0;
            r_gets      <= '0;
        end else begin
            if (r_out_valid && i_out_ready && !load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key       <= i_key;
                        r_rd_addr   <= '0;
                        r_rd_pend   <= 1'b0;
                        r_ahead     <= '0;
                        r_pend_rank <= '0;
                        if (i_op == OP_PUT) begin
                            r_state <= S_DONE;
                            if (put_ok) begin
                                r_fill        <= r_fill + CW'(1);
                                r_pend_status <= ST_STORED;
                            end else begin
                                r_pend_status <= ST_FULL;
                            end
                        end else if (r_fill == '0) begin
                            r_state       <= S_DONE;
                            r_pend_status <= ST_ABSENT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // read data comes from a registered read and trails the address into the next cycle
                    r_rd_idx  <= r_rd_addr[AW-1:0];
                    r_rd_pend <= (r_rd_addr < r_fill);
                    if (r_rd_addr < r_fill) begin
                        r_rd_addr <= r_rd_addr + CW'(1);
                    end
                    if (hit) begin
                        r_state       <= S_DONE;
                        r_pend_status <= ST_FOUND;
                        r_pend_rank   <= (ahead_ext > 32'(RANK_MAX)) ? RANK_MAX
                                                                      : ahead_ext[RANK_W-1:0];
                    end else if (r_rd_pend && r_live_rd) begin
                        r_ahead <= r_ahead + CW'(1);
                    end else if (!r_rd_pend && (r_rd_addr >= r_fill)) begin
                        r_state       <= S_DONE;
                        r_pend_status <= ST_ABSENT;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_status    <= r_pend_status;
                        r_rank      <= r_pend_rank;
                        if (r_pend_status == ST_FOUND) begin
                            r_sum <= n_sum;
                            if (r_pend_rank > r_max) begin
                                r_max <= r_pend_rank;
                            end
                            if (r_gets != GETS_MAX) begin
                                r_gets <= r_gets + GETS_W'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_rank_err   = r_rank;
    assign o_error_sum  = r_sum;
    assign o_error_max  = r_max;
    assign o_gets_done  = r_gets;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond store size");

    a_gets_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (r_pend_status == ST_FOUND)) |=>
            (r_gets != $past(r_gets)) || ($past(r_gets) == GETS_MAX))
        else $error("successful get not counted");

    a_rank_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (o_rank_err != '0)) |-> (o_status == ST_FOUND))
        else $error("nonzero rank error on a word that is not a hit");

    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_error_max >= o_rank_err))
        else $error("maximum below reported rank error");

    a_put_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_PUT)) |=> (r_state == S_DONE))
        else $error("put entered the scan");

endmodule
`default_nettype wire

// ===== dv/fifo_rank_error_tracker_tb.sv =====
// Self-checking testbench for the relaxed FIFO rank error tracker.
module fifo_rank_error_tracker_tb
    import fret_pkg::*;
();

    localparam int STORE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_WORDS = 543;
    localparam int PHASE_LEN = 136;

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] key;
        int unsigned      idle_pct;
        int unsigned      stall_pct;
        bit               drain;
        bit               hold;
    } t_tracker_word;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [RANK_W-1:0]   rank;
        logic [SUM_W-1:0]    sum;
        logic [RANK_W-1:0]   max;
        logic [GETS_W-1:0]   gets;
    } t_tracker_stats;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                op = OP_PUT;
    logic [KEY_W-1:0]    key = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   rank_err;
    logic [SUM_W-1:0]    error_sum;
    logic [RANK_W-1:0]   error_max;
    logic [GETS_W-1:0]   gets_done;

    fifo_rank_error_tracker #(
        .ENTRIES(STORE_DEPTH)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_op         (op),
        .i_key        (key),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_rank_err   (rank_err),
        .o_error_sum  (error_sum),
        .o_error_max  (error_max),
        .o_gets_done  (gets_done)
    );

    t_tracker_word    pending_words[$];
    t_tracker_stats   expected_stats[$];
    logic [KEY_W-1:0] offered_keys[$];
    int               puts_offered = 0;
    int               total_words = 0;
    int               accepted_words = 0;
    int               mismatches = 0;
    int               cycle_count = 0;

    // shadow copy of the tracker state
    logic [KEY_W-1:0]  shadow_keys[STORE_DEPTH];
    bit                shadow_live[STORE_DEPTH];
    int                shadow_fill = 0;
    logic [SUM_W-1:0]  shadow_sum = '0;
    logic [RANK_W-1:0] shadow_max = '0;
    logic [GETS_W-1:0] shadow_gets = '0;

    logic        in_fire = 1'b0;
    int unsigned stall_pct = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic void track_rank_step(input logic w_op, input logic [KEY_W-1:0] w_key);
        t_tracker_stats r;
        int ahead;
        int slot;
        r.status = ST_STORED;
        r.rank = '0;
        if (w_op == OP_PUT) begin
            if (shadow_fill >= STORE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                shadow_keys[shadow_fill] = w_key;
                shadow_live[shadow_fill] = 1'b1;
                shadow_fill++;
            end
        end else begin
            ahead = 0;
            slot = -1;
            for (int s = 0; s < shadow_fill && slot < 0; s++) begin
                if (shadow_live[s]) begin
                    if (shadow_keys[s] == w_key) slot = s;
                    else ahead++;
                end
            end
            if (slot < 0) begin
                r.status = ST_ABSENT;
            end else begin
                shadow_live[slot] = 1'b0;
                r.status = ST_FOUND;
                if (ahead > int'(RANK_MAX)) ahead = int'(RANK_MAX);
                r.rank = RANK_W'(ahead);
                if (int'(SUM_MAX) - int'(shadow_sum) < ahead) shadow_sum = SUM_MAX;
                else shadow_sum = shadow_sum + SUM_W'(ahead);
                if (r.rank > shadow_max) shadow_max = r.rank;
                if (shadow_gets < GETS_MAX) shadow_gets = shadow_gets + 1'b1;
            end
        end
        r.sum = shadow_sum;
        r.max = shadow_max;
        r.gets = shadow_gets;
        expected_stats.push_back(r);
    endfunction

    function automatic void queue_word(input logic w_op, input logic [KEY_W-1:0] w_key,
                                       input int unsigned idle, input int unsigned stall,
                                       input bit drain, input bit hold);
        t_tracker_word w;
        w.op = w_op;
        w.key = w_key;
        w.idle_pct = idle;
        w.stall_pct = stall;
        w.drain = drain;
        w.hold = hold;
        pending_words.push_back(w);
    endfunction

    function automatic void offer_put(input logic [KEY_W-1:0] w_key, input int unsigned idle,
                                      input int unsigned stall, input bit drain, input bit hold);
        queue_word(OP_PUT, w_key, idle, stall, drain, hold);
        // dropped puts into a full store never become gettable
        if (puts_offered < STORE_DEPTH) offered_keys.push_back(w_key);
        puts_offered++;
    endfunction

    // pick a key that should still be live; the head is favored to get rank 0 often
    function automatic logic [KEY_W-1:0] take_stored_key();
        int idx;
        logic [KEY_W-1:0] k;
        idx = ($urandom_range(3) == 0) ? 0 : $urandom_range(offered_keys.size() - 1);
        k = offered_keys[idx];
        offered_keys.delete(idx);
        return k;
    endfunction

    // a narrow key range now and then makes duplicate keys
    function automatic logic [KEY_W-1:0] fresh_key();
        if ($urandom_range(3) == 0) return KEY_W'($urandom_range(15));
        return $urandom;
    endfunction

    // driver
    always @(negedge clk) begin
        t_tracker_word head;
        bit            go;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            go = 1'b0;
            if (pending_words.size() > 0) begin
                go = ($urandom_range(99) >= pending_words[0].idle_pct);
                // a drain word waits until every result is out
                if (pending_words[0].drain && expected_stats.size() != 0) go = 1'b0;
            end
            if (go) begin
                head = pending_words.pop_front();
                op <= head.op;
                key <= head.key;
                stall_pct <= head.stall_pct;
                if (head.hold) hold_req <= hold_req + 1;
            end
            in_valid <= go;
        end
    end

    // receiver
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: check results first, then predict the word just taken
    always @(posedge clk) begin
        t_tracker_stats want;
        if (!rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: st=%0d rank=%0d sum=%0d max=%0d gets=%0d",
                                 status, rank_err, error_sum, error_max, gets_done);
                end else begin
                    want = expected_stats.pop_front();
                    if (status !== want.status || rank_err !== want.rank ||
                        error_sum !== want.sum || error_max !== want.max ||
                        gets_done !== want.gets) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: exp st=%0d rank=%0d sum=%0d max=%0d gets=%0d",
                                   want.status, want.rank, want.sum, want.max, want.gets);
                            $display(" / got st=%0d rank=%0d sum=%0d max=%0d gets=%0d",
                                     status, rank_err, error_sum, error_max, gets_done);
                        end
                    end
                end
            end
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                accepted_words++;
                track_rank_step(op, key);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int unsigned idle_by_phase[4];
        int unsigned stall_by_phase[4];
        int          ph;
        int          roll;
        bit          first;

        idle_by_phase = '{0, 81, 0, 12};
        stall_by_phase = '{0, 0, 81, 12};

        // directed: empty store, key extremes, duplicates, repeat and stale gets
        queue_word(OP_GET, '0, 0, 0, 0, 0);
        offer_put('0, 0, 0, 0, 0);
        offer_put('1, 0, 0, 0, 0);
        offer_put(32'hA5A5_5A5A, 0, 0, 0, 0);
        offer_put(32'h5A5A_A5A5, 0, 0, 0, 0);
        offer_put('0, 0, 0, 0, 0);
        queue_word(OP_GET, '1, 0, 0, 0, 0);
        queue_word(OP_GET, '0, 0, 0, 0, 0);
        queue_word(OP_GET, '0, 0, 0, 0, 0);
        queue_word(OP_GET, '0, 0, 0, 0, 0);
        queue_word(OP_GET, 32'h5A5A_A5A5, 0, 0, 0, 0);
        queue_word(OP_GET, 32'hA5A5_5A5A, 0, 0, 0, 0);
        queue_word(OP_GET, '1, 0, 0, 0, 0);
        offered_keys.delete();

        // random: mostly puts and gets of live keys, some gets of random keys
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            ph = (n / PHASE_LEN) % 4;
            first = (n % PHASE_LEN == 0);
            roll = $urandom_range(99);
            if (roll < 50 || offered_keys.size() == 0)
                offer_put(fresh_key(), idle_by_phase[ph], stall_by_phase[ph], first,
                          first && ph == 0);
            else if (roll < 90)
                queue_word(OP_GET, take_stored_key(), idle_by_phase[ph], stall_by_phase[ph],
                           first, first && ph == 0);
            else
                queue_word(OP_GET, fresh_key(), idle_by_phase[ph], stall_by_phase[ph],
                           first, first && ph == 0);
        end

        // tail: puts, gets of live and absent keys under mixed pacing
        for (int n = 0; n < 24; n++) begin
            ph = n % 4;
            roll = $urandom_range(2);
            if (roll == 0)
                offer_put(fresh_key(), idle_by_phase[ph], stall_by_phase[ph], 0, 0);
            else if (roll == 1 && offered_keys.size() > 0)
                queue_word(OP_GET, take_stored_key(), idle_by_phase[ph], stall_by_phase[ph],
                           0, 0);
            else
                queue_word(OP_GET, $urandom, idle_by_phase[ph], stall_by_phase[ph], 0, 0);
        end
        total_words = pending_words.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_words < total_words || expected_stats.size() != 0) @(posedge clk);
        repeat (STORE_DEPTH + 16) @(posedge clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
